### hdl/rbb_pkg.sv
`timescale 1ns / 1ps
package rbb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // Step queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Sum of three channel values, and of nine.
  localparam int unsigned COLSUM_W = 10;
  localparam int unsigned SUM_W    = 12;

  // floor(x / 9) = (x * 7282) >> 16 for x up to 9 * 255.
  localparam int unsigned      DIV9_MUL_W = 13;
  localparam logic [12:0]      DIV9_MUL   = 13'd7282;
  localparam int unsigned      DIV9_SHIFT = 16;

  // Result slots of one step: bit 0 upper row / left col, bit 1 upper row /
  // own col, bit 2 own row / left col, bit 3 own row / own col.
  localparam int unsigned SLOTS = 4;

  // 3x3 window, element col*3 + row; col 2 newest, row 0 upper line.
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               col_ge1;
    logic               col_ge2;
    logic               row_ge1;
    logic               row_ge2;
    logic               frame_end;
    logic [SLOTS-1:0]   mask;
  } step_t;

endpackage

### hdl/rbb_pix_if.sv
`timescale 1ns / 1ps
interface rbb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_blue;
  logic [7:0] pix_green;
  logic [7:0] pix_red;

  modport source (output valid, output pix_blue, output pix_green, output pix_red,
                  input ready);
  modport sink   (input valid, input pix_blue, input pix_green, input pix_red,
                  output ready);
endinterface

### hdl/rbb_res_if.sv
`timescale 1ns / 1ps
interface rbb_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] out_col;
  logic [10:0] out_row;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        last_of_step;
  logic        frame_done;

  modport source (output valid, output out_col, output out_row, output out_blue,
                  output out_green, output out_red, output last_of_step,
                  output frame_done, input ready);
  modport sink   (input valid, input out_col, input out_row, input out_blue,
                  input out_green, input out_red, input last_of_step,
                  input frame_done, output ready);
endinterface

### hdl/rbb_ram.sv
`timescale 1ns / 1ps
module rbb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word when both ports hit the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rbb_fifo.sv
`timescale 1ns / 1ps
module rbb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [LW-1:0]    level_q, level_d;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    level_d = level_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rd_q];
  assign empty_o = (level_q == '0);
  assign level_o = level_q;

endmodule

### hdl/rbb_front.sv
`timescale 1ns / 1ps
module rbb_front #(
  parameter int unsigned MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [rbb_pkg::DIM_W-1:0]                frame_width_i,
  input  logic [rbb_pkg::DIM_W-1:0]                frame_height_i,
  rbb_pix_if.sink                                  pix_i,
  input  logic [$clog2(rbb_pkg::QUEUE_DEPTH+1)-1:0] level_i,
  output logic                                     push_o,
  output rbb_pkg::step_t                           step_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WDW = (CW + 1 > rbb_pkg::DIM_W) ? CW + 1 : rbb_pkg::DIM_W;
  localparam int unsigned HDW = (RW + 1 > rbb_pkg::DIM_W) ? RW + 1 : rbb_pkg::DIM_W;
  localparam int unsigned LW  = $clog2(rbb_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned PXW = rbb_pkg::PIX_W;
  localparam int unsigned COW = rbb_pkg::COORD_W;

  logic [WDW-1:0] fw, w_eff;
  logic [HDW-1:0] fh, h_eff;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           last_col, last_row, accept;

  logic           s1_valid_q;
  logic [CW-1:0]  s1_idx_q;
  logic [PXW-1:0] s1_pix_q;
  logic [COW-1:0] s1_col_q, s1_row_q;
  logic           s1_cge1_q, s1_cge2_q, s1_rge1_q, s1_rge2_q;
  logic           s1_lcol_q, s1_lrow_q;
  logic           hit_q;
  logic [PXW-1:0] fwd_prev_q, fwd_cur_q;
  rbb_pkg::win_t  win_q, win_d;

  logic [PXW-1:0] ram_prev, ram_cur, up, mid, pix;
  logic [rbb_pkg::SLOTS-1:0] mask;

  // Clamp geometry to 1..MAX.
  always_comb begin
    fw = WDW'(frame_width_i);
    fh = HDW'(frame_height_i);
    if (fw == '0) begin
      w_eff = WDW'(1);
    end else if (fw > WDW'(MAX_WIDTH)) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = fw;
    end
    if (fh == '0) begin
      h_eff = HDW'(1);
    end else if (fh > HDW'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = fh;
    end
  end

  assign last_col = (WDW'(col_q) >= w_eff - WDW'(1));
  assign last_row = (HDW'(row_q) >= h_eff - HDW'(1));
  assign pix      = {pix_i.pix_red, pix_i.pix_green, pix_i.pix_blue};

  // The step held in the s1 registers plus the queue contents must fit the queue.
  assign pix_i.ready = (LW'(level_i) + LW'(s1_valid_q)) < LW'(rbb_pkg::QUEUE_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  rbb_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_prev_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_idx_q),
    .wdata_i (mid),
    .raddr_i (col_q),
    .rdata_o (ram_prev)
  );

  rbb_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_cur_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_pix_q),
    .raddr_i (col_q),
    .rdata_o (ram_cur)
  );

  // Forward the write that lands on the same edge as this read.
  assign up  = hit_q ? fwd_prev_q : ram_prev;
  assign mid = hit_q ? fwd_cur_q  : ram_cur;

  assign win_d = {s1_pix_q, mid, up, win_q[8:3]};

  assign mask[0] = s1_rge1_q && s1_cge1_q;
  assign mask[1] = s1_rge1_q && s1_lcol_q;
  assign mask[2] = s1_lrow_q && s1_cge1_q;
  assign mask[3] = s1_lrow_q && s1_lcol_q;

  assign push_o            = s1_valid_q && (mask != '0);
  assign step_o.win        = win_d;
  assign step_o.col        = s1_col_q;
  assign step_o.row        = s1_row_q;
  assign step_o.col_ge1    = s1_cge1_q;
  assign step_o.col_ge2    = s1_cge2_q;
  assign step_o.row_ge1    = s1_rge1_q;
  assign step_o.row_ge2    = s1_rge2_q;
  assign step_o.frame_end  = s1_lrow_q && s1_lcol_q;
  assign step_o.mask       = mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      if (accept) begin
        hit_q <= s1_valid_q && (s1_idx_q == col_q);
      end
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= col_q;
      s1_pix_q   <= pix;
      s1_col_q   <= COW'(col_q);
      s1_row_q   <= COW'(row_q);
      s1_cge1_q  <= (col_q != '0);
      s1_cge2_q  <= (WDW'(col_q) >= WDW'(2));
      s1_rge1_q  <= (row_q != '0);
      s1_rge2_q  <= (HDW'(row_q) >= HDW'(2));
      s1_lcol_q  <= last_col;
      s1_lrow_q  <= last_row;
      fwd_prev_q <= mid;
      fwd_cur_q  <= s1_pix_q;
    end
  end

endmodule

### hdl/rbb_back.sv
`timescale 1ns / 1ps
module rbb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbb_pkg::step_t step_i,
  input  logic           empty_i,
  output logic           pop_o,
  rbb_res_if.source      res_o
);

  localparam int unsigned CSW = rbb_pkg::COLSUM_W;
  localparam int unsigned SW  = rbb_pkg::SUM_W;
  localparam int unsigned COW = rbb_pkg::COORD_W;
  localparam int unsigned CHW = rbb_pkg::CHAN_W;
  localparam int unsigned NS  = rbb_pkg::SLOTS;

  logic [NS-1:0] done_q, remain, sel;
  logic          issue, last;
  logic          rs, cs;
  logic [1:0]    cidx [3];
  logic [1:0]    ridx [3];
  logic [2:0][2:0][CSW-1:0] colsum;

  // Stage A: column sums.
  logic                     a_valid_q;
  logic [2:0][2:0][CSW-1:0] a_sum_q;
  logic [COW-1:0]           a_col_q, a_row_q;
  logic                     a_last_q, a_done_q;
  // Stage B: window sums.
  logic                     b_valid_q;
  logic [2:0][SW-1:0]       b_sum_q;
  logic [COW-1:0]           b_col_q, b_row_q;
  logic                     b_last_q, b_done_q;
  // Output register.
  logic                     o_valid_q;
  logic [2:0][CHW-1:0]      o_pix_q;
  logic [COW-1:0]           o_col_q, o_row_q;
  logic                     o_last_q, o_done_q;

  logic take_o, take_b, take_a;
  logic [2:0][SW-1:0] total;
  logic [2:0][CHW-1:0] quot;

  assign take_o = !o_valid_q || res_o.ready;
  assign take_b = !b_valid_q || take_o;
  assign take_a = !a_valid_q || take_b;

  // Pick the lowest pending slot of the head step.
  assign remain = step_i.mask & ~done_q;
  assign sel    = remain & (~remain + NS'(1));
  assign last   = ((remain & ~sel) == '0);
  assign issue  = !empty_i && take_a;
  assign pop_o  = issue && last;

  assign rs = sel[2] | sel[3];
  assign cs = sel[1] | sel[3];

  always_comb begin
    logic [3:0] widx;
    if (cs) begin
      cidx[0] = step_i.col_ge1 ? 2'd1 : 2'd2;
      cidx[1] = 2'd2;
      cidx[2] = 2'd2;
    end else begin
      cidx[0] = step_i.col_ge2 ? 2'd0 : 2'd1;
      cidx[1] = 2'd1;
      cidx[2] = 2'd2;
    end
    if (rs) begin
      ridx[0] = step_i.row_ge1 ? 2'd1 : 2'd2;
      ridx[1] = 2'd2;
      ridx[2] = 2'd2;
    end else begin
      ridx[0] = step_i.row_ge2 ? 2'd0 : 2'd1;
      ridx[1] = 2'd1;
      ridx[2] = 2'd2;
    end
    colsum = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        widx = 4'(cidx[a]) * 4'd3 + 4'(ridx[b]);
        for (int ch = 0; ch < 3; ch++) begin
          colsum[ch][a] = colsum[ch][a] + CSW'(step_i.win[widx][ch*CHW +: CHW]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = SW'(a_sum_q[ch][0]) + SW'(a_sum_q[ch][1]) + SW'(a_sum_q[ch][2]);
    end
  end

  always_comb begin
    logic [SW+rbb_pkg::DIV9_MUL_W-1:0] prod;
    prod = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod     = (SW + rbb_pkg::DIV9_MUL_W)'(b_sum_q[ch]) *
                 (SW + rbb_pkg::DIV9_MUL_W)'(rbb_pkg::DIV9_MUL);
      quot[ch] = prod[rbb_pkg::DIV9_SHIFT +: CHW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        done_q <= last ? '0 : (done_q | sel);
      end
      if (take_a) begin
        a_valid_q <= issue;
      end
      if (take_b) begin
        b_valid_q <= a_valid_q;
      end
      if (take_o) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_a) begin
      a_sum_q  <= colsum;
      a_col_q  <= cs ? step_i.col : step_i.col - COW'(1);
      a_row_q  <= rs ? step_i.row : step_i.row - COW'(1);
      a_last_q <= last;
      a_done_q <= last && step_i.frame_end;
    end
    if (take_b) begin
      b_sum_q  <= total;
      b_col_q  <= a_col_q;
      b_row_q  <= a_row_q;
      b_last_q <= a_last_q;
      b_done_q <= a_done_q;
    end
    if (take_o) begin
      o_pix_q  <= quot;
      o_col_q  <= b_col_q;
      o_row_q  <= b_row_q;
      o_last_q <= b_last_q;
      o_done_q <= b_done_q;
    end
  end

  assign res_o.valid        = o_valid_q;
  assign res_o.out_col      = o_col_q;
  assign res_o.out_row      = o_row_q;
  assign res_o.out_blue     = o_pix_q[0];
  assign res_o.out_green    = o_pix_q[1];
  assign res_o.out_red      = o_pix_q[2];
  assign res_o.last_of_step = o_last_q;
  assign res_o.frame_done   = o_done_q;

endmodule

### hdl/rgb_box_blur_3x3_clamped.sv
`timescale 1ns / 1ps
// Channel    Dir  Handshake       Payload
// pix_i      in   valid / ready   pix_blue, pix_green, pix_red
// res_o      out  valid / ready   out_col, out_row, out_blue/green/red,
//                                 last_of_step, frame_done
// cfg        in   cfg_we_i        cfg_idx_i, cfg_data_i (write only)
//
// One pixel is taken per clock while the four-entry step queue has room.
// A step's results leave one per clock while res_o is ready. Between the pixel
// transfer and its first result lie the line store read, step queue, column
// sums, window sums and divide-by-nine multiply into the output register.
// Reset clears counters, window and all valid flags; line stores hold stale
// data that never reaches a result in a well-formed frame.
// A stalled res_o backs up the three back stages, then the queue, then pix_i.
module rgb_box_blur_3x3_clamped #(
  parameter int unsigned MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rbb_pix_if.sink                        pix_i,
  rbb_res_if.source                      res_o
);

  localparam int unsigned LW = $clog2(rbb_pkg::QUEUE_DEPTH + 1);

  logic [rbb_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
  logic                      push, pop, empty;
  logic [LW-1:0]             level;
  rbb_pkg::step_t            step_in, step_out;

  // Geometry registers; user writes only while block is idle, unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rbb_pkg::FRAME_WIDTH_RST;
      frame_height_q <= rbb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbb_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        rbb_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: count position, keep line stores and window, classify the step.
  rbb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .pix_i          (pix_i),
    .level_i        (level),
    .push_o         (push),
    .step_o         (step_in)
  );

  // Hold steps that carry at least one result.
  rbb_fifo #(.WIDTH($bits(rbb_pkg::step_t)), .DEPTH(rbb_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (step_in),
    .pop_i   (pop),
    .rdata_o (step_out),
    .empty_o (empty),
    .level_o (level)
  );

  // Back: expand each step into its results and filter them.
  rbb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_out),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

### tb/rbb_blur_checker.sv
`timescale 1ns / 1ps
module rbb_blur_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rbb_pix_if                             pix,
  rbb_res_if                             res,
  output int                             mismatches_o,
  output int                             blur_pending_o,
  output int                             blur_checked_o
);

  typedef struct packed {
    logic [rbb_pkg::COORD_W-1:0] col;
    logic [rbb_pkg::COORD_W-1:0] row;
    logic [rbb_pkg::CHAN_W-1:0]  blue;
    logic [rbb_pkg::CHAN_W-1:0]  green;
    logic [rbb_pkg::CHAN_W-1:0]  red;
    logic                        last_of_step;
    logic                        frame_done;
  } blur_px_t;

  blur_px_t                  blur_q[$];
  logic [rbb_pkg::DIM_W-1:0] width_reg, height_reg;
  logic [rbb_pkg::PIX_W-1:0] line_up[rbb_pkg::MAX_WIDTH_DEF];
  logic [rbb_pkg::PIX_W-1:0] line_mid[rbb_pkg::MAX_WIDTH_DEF];
  logic [rbb_pkg::PIX_W-1:0] win[9];
  int unsigned               col_cnt, row_cnt;

  assign blur_pending_o = blur_q.size();

  function automatic logic [rbb_pkg::CHAN_W-1:0] box_avg(input int unsigned cl[3],
                                                         input int unsigned rw[3],
                                                         input int sh);
    int unsigned sum;
    sum = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        sum += (win[(cl[a] * 3 + rw[b]) % 9] >> sh) & 8'hFF;
    return rbb_pkg::CHAN_W'(sum / 9);
  endfunction

  // Advance the window and counters by one pixel, queue the filtered pixels it completes.
  task automatic blur_pixel(input logic [rbb_pkg::PIX_W-1:0] p);
    int unsigned w, h, c, r, idx, n;
    int unsigned rw[3], cl[3];
    logic [rbb_pkg::PIX_W-1:0] up, mid;
    logic last_col, last_row;
    blur_px_t e;
    w = (width_reg == 0) ? 1 :
        (width_reg > rbb_pkg::MAX_WIDTH_DEF ? rbb_pkg::MAX_WIDTH_DEF : width_reg);
    h = (height_reg == 0) ? 1 :
        (height_reg > rbb_pkg::MAX_HEIGHT_DEF ? rbb_pkg::MAX_HEIGHT_DEF : height_reg);
    c = col_cnt;
    r = row_cnt;
    idx = (c < rbb_pkg::MAX_WIDTH_DEF) ? c : rbb_pkg::MAX_WIDTH_DEF - 1;
    up = line_up[idx];
    mid = line_mid[idx];
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    line_up[idx] = mid;
    line_mid[idx] = p;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = up;
    win[7] = mid;
    win[8] = p;
    n = 0;
    for (int rs = 0; rs < 2; rs++) begin
      if (rs == 0 && r < 1) continue;
      if (rs == 1 && !last_row) continue;
      if (rs == 0) begin
        rw[0] = (r >= 2) ? 0 : 1; rw[1] = 1; rw[2] = 2;
      end else begin
        rw[0] = (r >= 1) ? 1 : 2; rw[1] = 2; rw[2] = 2;
      end
      for (int cs = 0; cs < 2; cs++) begin
        if (cs == 0 && c < 1) continue;
        if (cs == 1 && !last_col) continue;
        if (cs == 0) begin
          cl[0] = (c >= 2) ? 0 : 1; cl[1] = 1; cl[2] = 2;
        end else begin
          cl[0] = (c >= 1) ? 1 : 2; cl[1] = 2; cl[2] = 2;
        end
        e.col   = rbb_pkg::COORD_W'(cs == 0 ? c - 1 : c);
        e.row   = rbb_pkg::COORD_W'(rs == 0 ? r - 1 : r);
        e.blue  = box_avg(cl, rw, 0);
        e.green = box_avg(cl, rw, 8);
        e.red   = box_avg(cl, rw, 16);
        e.last_of_step = 1'b0;
        e.frame_done   = 1'b0;
        blur_q.push_back(e);
        n++;
      end
    end
    if (n > 0) begin
      blur_q[$].last_of_step = 1'b1;
      blur_q[$].frame_done   = last_row && last_col;
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_px_t got, want;
    if (!rst_ni) begin
      width_reg = rbb_pkg::FRAME_WIDTH_RST;
      height_reg = rbb_pkg::FRAME_HEIGHT_RST;
      col_cnt = 0;
      row_cnt = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < rbb_pkg::MAX_WIDTH_DEF; i++) begin
        line_up[i] = '0;
        line_mid[i] = '0;
      end
      blur_q.delete();
      mismatches_o <= 0;
      blur_checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rbb_pkg::REG_FRAME_WIDTH) width_reg = cfg_data_i;
        else if (cfg_idx_i == rbb_pkg::REG_FRAME_HEIGHT) height_reg = cfg_data_i;
      end
      if (pix.valid && pix.ready)
        blur_pixel({pix.pix_red, pix.pix_green, pix.pix_blue});
      if (res.valid && res.ready) begin
        got = '{res.out_col, res.out_row, res.out_blue, res.out_green, res.out_red,
                res.last_of_step, res.frame_done};
        blur_checked_o <= blur_checked_o + 1;
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = blur_q.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end
endmodule

### tb/rgb_box_blur_3x3_clamped_tb.sv
`timescale 1ns / 1ps
module rgb_box_blur_3x3_clamped_tb;

  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  // Pipeline depth plus margin: let a step that yields nothing finish.
  localparam int SETTLE = 16;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i = rbb_pkg::REG_FRAME_WIDTH;
  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           calm = 1'b0;
  int                             mismatches, blur_pending, blur_checked;
  int                             pixels_sent = 0;
  int                             frames_sent = 0;
  int                             hang_cnt = 0;

  rbb_pix_if pix();
  rbb_res_if res();

  rgb_box_blur_3x3_clamped DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix), .res_o(res)
  );

  rbb_blur_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix(pix), .res(res),
    .mismatches_o(mismatches), .blur_pending_o(blur_pending),
    .blur_checked_o(blur_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    pix.valid = 1'b0;
    pix.pix_blue = '0;
    pix.pix_green = '0;
    pix.pix_red = '0;
    res.ready = 1'b0;
  end

  // Stall the result side about 28% of cycles, except in the calm stretch.
  always @(posedge clk_i)
    res.ready <= calm || ($urandom_range(99) >= 28);

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) hang_cnt <= 0;
      else hang_cnt <= hang_cnt + 1;
      if (hang_cnt >= HANG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Hold the pixel until it is taken; idle at random beforehand.
  task automatic send_pixel(input logic [23:0] p);
    while (!calm && $urandom_range(99) < 28) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    {pix.pix_red, pix.pix_green, pix.pix_blue} <= p;
    do @(posedge clk_i); while (!pix.ready);
    pixels_sent++;
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] p;
    p = 24'($urandom);
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      2: p[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return p;
  endfunction

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (blur_pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int w, input int h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rbb_pkg::REG_FRAME_WIDTH;
    cfg_data_i <= rbb_pkg::CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_idx_i <= rbb_pkg::REG_FRAME_HEIGHT;
    cfg_data_i <= rbb_pkg::CFG_DATA_W'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Configure, stream one whole frame, drain.
  task automatic run_frame(input int w, input int h);
    int we, he;
    we = (w < 1) ? 1 : (w > rbb_pkg::MAX_WIDTH_DEF ? rbb_pkg::MAX_WIDTH_DEF : w);
    he = (h < 1) ? 1 : (h > rbb_pkg::MAX_HEIGHT_DEF ? rbb_pkg::MAX_HEIGHT_DEF : h);
    set_geometry(w, h);
    for (int i = 0; i < we * he; i++) send_pixel(rand_pixel());
    drain();
    frames_sent++;
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single pixel, corner-only frames, saturated and empty values.
    set_geometry(1, 1);
    send_pixel(24'hFFFFFF);
    drain();
    set_geometry(2, 2);
    send_pixel(24'h000000); send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF); send_pixel(24'h000000);
    drain();
    set_geometry(3, 1);
    send_pixel(24'hAA55FF); send_pixel(24'h55AA00); send_pixel(24'hFFFFFF);
    drain();
    // Height shrunk mid-frame: the frame ends with the current row.
    set_geometry(4, 10);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? 24'hFFFFFF : 24'h000000);
    drain();
    set_geometry(4, 2);
    for (int i = 0; i < 4; i++) send_pixel(24'hFFFFFF);
    drain();
    frames_sent += 4;

    // Random small frames; a calm stretch with no idling in the middle.
    target = pixels_sent + 310;
    while (pixels_sent < target) begin
      calm = (frames_sent >= 10 && frames_sent < 16);
      if ($urandom_range(19) == 0) run_frame(0, $urandom_range(0, 4));
      else run_frame($urandom_range(1, 12), $urandom_range(1, 6));
    end
    calm = 1'b0;

    // Zero geometry, clamped to a single pixel.
    run_frame(0, 0);

    $display("Sent %0d pixels in %0d frames, %0d filtered pixels checked,", pixels_sent,
             frames_sent, blur_checked);
    $display("covering edge clamping, one-pixel frames, clamped and mid-frame geometry.");
    if (mismatches == 0 && blur_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### sim.f
hdl/rbb_pkg.sv
hdl/rbb_pix_if.sv
hdl/rbb_res_if.sv
hdl/rbb_ram.sv
hdl/rbb_fifo.sv
hdl/rbb_front.sv
hdl/rbb_back.sv
hdl/rgb_box_blur_3x3_clamped.sv
tb/rbb_blur_checker.sv
tb/rgb_box_blur_3x3_clamped_tb.sv
